@@ rtl/lfc_pkg.sv @@
`timescale 1ns / 1ps
// lfc_pkg: shared constants, codes and control structs of the life core
// no dependencies; used by lfc_cell, lfc_array and life_cellular_automaton_core
package lfc_pkg;

  localparam int ROWS       = 16;
  localparam int COLS       = 16;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int COL_W      = $clog2(COLS);
  localparam int AREA_ROW_W = $clog2(ROWS + 1);
  localparam int AREA_COL_W = $clog2(COLS + 1);
  localparam int NBR_CNT_W  = 4;

  localparam int CMD_W      = 2;
  localparam int ADDR_W     = 4;
  localparam int GEN_W      = 16;
  localparam int DIM_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [GEN_W-1:0] GEN_LIMIT_RST = GEN_W'(1000);
  localparam logic [DIM_W-1:0] ROWS_RST      = DIM_W'(16);
  localparam logic [DIM_W-1:0] COLS_RST      = DIM_W'(16);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GEN_LIMIT = 2'd0,
    CFG_ROWS      = 2'd1,
    CFG_COLS      = 2'd2
  } cfg_idx_e;

  // per-cell control, broadcast along the array
  typedef struct packed {
    logic step;
    logic snap;
    logic wr_val;
  } cell_ctrl_t;

  typedef struct packed {
    logic             step;
    logic             snap;
    logic             wr;
    logic             wr_val;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } arr_ctrl_t;

endpackage

@@ rtl/lfc_cell.sv @@
`timescale 1ns / 1ps
// lfc_cell: one board cell with its live bit and snapshot bit
// depends on lfc_pkg
module lfc_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lfc_pkg::cell_ctrl_t   ctrl_i,
  input  logic                  wr_sel_i,
  input  logic                  in_area_i,
  input  logic [7:0]            nbr_i,
  output logic                  live_o,
  output logic                  now_d_o,
  output logic                  diff_o
);

  logic now_q, now_d;
  logic snap_q, snap_d;
  logic [lfc_pkg::NBR_CNT_W-1:0] cnt;
  logic rule_live;

  assign cnt       = lfc_pkg::NBR_CNT_W'($countones(nbr_i));
  assign rule_live = (cnt == lfc_pkg::NBR_CNT_W'(3)) ||
                     (now_q && (cnt == lfc_pkg::NBR_CNT_W'(2)));

  always_comb begin
    if (ctrl_i.step) begin
      // cells off the area are cleared by a step
      now_d = in_area_i & rule_live;
    end else if (wr_sel_i) begin
      now_d = ctrl_i.wr_val;
    end else begin
      now_d = now_q;
    end
  end

  // snapshot takes the board from before a step, on steps that have snap set
  assign snap_d = (ctrl_i.step && ctrl_i.snap) ? now_q : snap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q  <= 1'b0;
      snap_q <= 1'b0;
    end else begin
      now_q  <= now_d;
      snap_q <= snap_d;
    end
  end

  assign live_o  = now_q & in_area_i;
  assign now_d_o = now_d;
  assign diff_o  = in_area_i & (snap_d ^ now_d);

endmodule

@@ rtl/lfc_array.sv @@
`timescale 1ns / 1ps
// lfc_array: grid of lfc_cell with neighbor wiring, snapshot compare and read port
// depends on lfc_pkg and lfc_cell
module lfc_array (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lfc_pkg::arr_ctrl_t               ctrl_i,
  input  logic [lfc_pkg::AREA_ROW_W-1:0]   area_rows_i,
  input  logic [lfc_pkg::AREA_COL_W-1:0]   area_cols_i,
  output logic                             cell_o,
  output logic                             same_o
);

  logic [lfc_pkg::COLS-1:0]   live_row [lfc_pkg::ROWS];
  logic [lfc_pkg::COLS-1:0]   now_d_row [lfc_pkg::ROWS];
  logic [lfc_pkg::COLS-1:0]   diff_row [lfc_pkg::ROWS];
  logic [lfc_pkg::COLS+1:0]   live_pad [lfc_pkg::ROWS+2];
  logic [lfc_pkg::ROWS-1:0]   row_diff;
  lfc_pkg::cell_ctrl_t        cell_ctrl;

  assign cell_ctrl.step   = ctrl_i.step;
  assign cell_ctrl.snap   = ctrl_i.snap;
  assign cell_ctrl.wr_val = ctrl_i.wr_val;

  // dead border around the board
  assign live_pad[0]              = '0;
  assign live_pad[lfc_pkg::ROWS+1] = '0;

  for (genvar r = 0; r < lfc_pkg::ROWS; r++) begin : g_row
    assign live_pad[r+1] = {1'b0, live_row[r], 1'b0};
    assign row_diff[r]   = |diff_row[r];

    for (genvar c = 0; c < lfc_pkg::COLS; c++) begin : g_col
      logic       in_area;
      logic       wr_sel;
      logic [7:0] nbr;

      assign in_area = (area_rows_i > lfc_pkg::AREA_ROW_W'(r)) &&
                       (area_cols_i > lfc_pkg::AREA_COL_W'(c));
      assign wr_sel  = ctrl_i.wr && in_area &&
                       (ctrl_i.row == lfc_pkg::ROW_W'(r)) &&
                       (ctrl_i.col == lfc_pkg::COL_W'(c));
      assign nbr     = {live_pad[r][c+2:c], live_pad[r+1][c+2], live_pad[r+1][c],
                        live_pad[r+2][c+2:c]};

      lfc_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (cell_ctrl),
        .wr_sel_i  (wr_sel),
        .in_area_i (in_area),
        .nbr_i     (nbr),
        .live_o    (live_row[r][c]),
        .now_d_o   (now_d_row[r][c]),
        .diff_o    (diff_row[r][c])
      );
    end
  end

  assign same_o = ~|row_diff;
  assign cell_o = now_d_row[ctrl_i.row][ctrl_i.col];

endmodule

@@ rtl/life_cellular_automaton_core.sv @@
`timescale 1ns / 1ps
// life_cellular_automaton_core: B3/S23 life board with write, read and step commands
// depends on lfc_pkg and lfc_array
//
// Every accepted input word gives exactly one result word, registered in the next cycle.
// The 16x16 cell array works out the whole next generation and
// the snapshot compare in the same cycle, so with the result taken promptly the core
// takes a new word every cycle; it stalls only while the result register is full and
// not being drained. Board and flags are valid straight out of reset, no clearing pass.
module life_cellular_automaton_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lfc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lfc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [lfc_pkg::CMD_W-1:0]        cmd_i,
  input  logic [lfc_pkg::ADDR_W-1:0]       row_i,
  input  logic [lfc_pkg::ADDR_W-1:0]       col_i,
  input  logic                             cell_in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             cell_out_o,
  output logic [lfc_pkg::GEN_W-1:0]        gen_count_o,
  output logic                             stuck_flag_o,
  output logic                             over_flag_o
);

  logic [lfc_pkg::GEN_W-1:0]       gen_limit_q;
  logic [lfc_pkg::DIM_W-1:0]       rows_q, cols_q;
  logic [lfc_pkg::GEN_W-1:0]       gen_q, gen_d;
  logic                            take_q, take_d;
  logic                            stuck_q, stuck_d;
  logic                            out_valid_q, out_valid_d;
  logic                            cell_out_q;
  logic [lfc_pkg::GEN_W-1:0]       gen_out_q;
  logic                            stuck_out_q, over_out_q;

  logic                            accept;
  logic                            is_write, is_step;
  logic                            step_go;
  logic                            addr_in_area;
  logic                            arr_cell, arr_same;
  logic [lfc_pkg::AREA_ROW_W-1:0]  area_rows;
  logic [lfc_pkg::AREA_COL_W-1:0]  area_cols;
  lfc_pkg::arr_ctrl_t              arr_ctrl;

  // config port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_limit_q <= lfc_pkg::GEN_LIMIT_RST;
      rows_q      <= lfc_pkg::ROWS_RST;
      cols_q      <= lfc_pkg::COLS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lfc_pkg::CFG_GEN_LIMIT: gen_limit_q <= cfg_data_i[lfc_pkg::GEN_W-1:0];
        lfc_pkg::CFG_ROWS:      rows_q      <= cfg_data_i[lfc_pkg::DIM_W-1:0];
        lfc_pkg::CFG_COLS:      cols_q      <= cfg_data_i[lfc_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // area clamped to the board
  assign area_rows = (int'(rows_q) > lfc_pkg::ROWS) ? lfc_pkg::AREA_ROW_W'(lfc_pkg::ROWS)
                                                   : lfc_pkg::AREA_ROW_W'(rows_q);
  assign area_cols = (int'(cols_q) > lfc_pkg::COLS) ? lfc_pkg::AREA_COL_W'(lfc_pkg::COLS)
                                                   : lfc_pkg::AREA_COL_W'(cols_q);

  assign addr_in_area = (int'(row_i) < int'(area_rows)) && (int'(col_i) < int'(area_cols));

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    is_write = 1'b0;
    is_step  = 1'b0;
    unique case (cmd_i)
      lfc_pkg::CMD_WRITE: is_write = 1'b1;
      lfc_pkg::CMD_STEP:  is_step  = 1'b1;
      lfc_pkg::CMD_READ:  ;
      default: ;
    endcase
  end

  // steps are ignored once the count sits at the limit
  assign step_go = accept && is_step && (gen_q != gen_limit_q);

  assign arr_ctrl.step   = step_go;
  assign arr_ctrl.snap   = take_q;
  assign arr_ctrl.wr     = accept && is_write;
  assign arr_ctrl.wr_val = cell_in_i;
  assign arr_ctrl.row    = lfc_pkg::ROW_W'(row_i);
  assign arr_ctrl.col    = lfc_pkg::COL_W'(col_i);

  lfc_array u_array (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (arr_ctrl),
    .area_rows_i (area_rows),
    .area_cols_i (area_cols),
    .cell_o      (arr_cell),
    .same_o      (arr_same)
  );

  assign take_d  = step_go ? !take_q : take_q;
  assign stuck_d = (step_go && arr_same) ? 1'b1 : stuck_q;
  assign gen_d   = (step_go && !arr_same && !stuck_q) ? gen_q + lfc_pkg::GEN_W'(1) : gen_q;

  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q       <= '0;
      take_q      <= 1'b1;
      stuck_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      gen_q       <= gen_d;
      take_q      <= take_d;
      stuck_q     <= stuck_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cell_out_q  <= addr_in_area & arr_cell;
      gen_out_q   <= gen_d;
      stuck_out_q <= stuck_d;
      over_out_q  <= (gen_d == gen_limit_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_out_o   = cell_out_q;
  assign gen_count_o  = gen_out_q;
  assign stuck_flag_o = stuck_out_q;
  assign over_flag_o  = over_out_q;

  // stuck flag is sticky
  a_stuck_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stuck_q |=> stuck_q)
    else $error("stuck flag dropped");

  // count moves only on a taken step
  a_gen_only_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_go |=> $stable(gen_q))
    else $error("generation count moved without a step");

  // once stuck the count freezes
  a_gen_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stuck_q |=> $stable(gen_q))
    else $error("generation count moved while stuck");

  // snapshot phase alternates with every taken step
  a_snap_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_go |=> (take_q != $past(take_q)))
    else $error("snapshot phase did not toggle");

endmodule
